### rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// Package for the positional list engine: sizes, command and status codes,
// per-cell control struct and value conversion helpers. No dependencies.
package ple_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [2:0] {
        CMD_INS_FIRST = 3'd0,
        CMD_INS_LAST  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FIRST = 3'd3,
        CMD_DEL_LAST  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_DUMP      = 3'd6
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Shift operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_idx     k;     // insert/delete index, or last index for rotate
        t_data    data;  // value written by an insert
    } t_cell_ctrl;

    // Sign-extend a 32-bit input and keep the low DATA_WIDTH bits
    function automatic t_data to_store(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[DATA_WIDTH-1:0];
    endfunction

    // Sign-extend a stored value from DATA_WIDTH and keep 32 bits
    function automatic logic [31:0] to_element(input t_data d);
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           w;
        s = d;
        w = 64'(s);
        return w[31:0];
    endfunction

endpackage

### rtl/core/ple_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for command beats and result beats.
// Depends on ple_pkg.
interface ple_cmd_if import ple_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [7:0]         position;

    modport source (output valid, command, value, position, input ready);
    modport sink   (input valid, command, value, position, output ready);
endinterface

interface ple_res_if import ple_pkg::*; ();
    logic               valid;
    logic               ready;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;
    logic [CNT_W-1:0]   count;
    logic [1:0]         status;

    modport source (output valid, element, element_valid, last, count, status,
                    input ready);
    modport sink   (input valid, element, element_valid, last, count, status,
                    output ready);
endinterface

### rtl/core/ple_cell.sv
`timescale 1ns / 1ps
// One slot of the list chain: holds a value and loads from a neighbor,
// the new value or the head, as the broadcast op says. Depends on ple_pkg.
module ple_cell import ple_pkg::*; (
    input  logic       i_clk,
    input  t_idx       i_index,
    input  t_cell_ctrl i_ctrl,
    input  t_data      i_left,
    input  t_data      i_right,
    input  t_data      i_head,
    output t_data      o_data
);

    t_data r_data;
    t_data n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            CELL_INS: begin
                if (i_index == i_ctrl.k) begin
                    n_data = i_ctrl.data;
                end else if (i_index > i_ctrl.k) begin
                    n_data = i_left;
                end
            end
            CELL_DEL: begin
                if (i_index >= i_ctrl.k) begin
                    n_data = i_right;
                end
            end
            CELL_ROT: begin
                // rotate the occupied part by one: head wraps to the last slot
                if (i_index < i_ctrl.k) begin
                    n_data = i_right;
                end else if (i_index == i_ctrl.k) begin
                    n_data = i_head;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

### rtl/core/ple_chain.sv
`timescale 1ns / 1ps
// Row of CAPACITY list cells wired to their neighbors; exposes the head.
// Depends on ple_pkg and ple_cell.
module ple_chain import ple_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    output t_data      o_head
);

    t_data w_data [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_data w_left;
        t_data w_right;

        if (g == 0) begin : g_first
            assign w_left = i_ctrl.data;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (i_ctrl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

### rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// Positional list engine top level: command decode, dump sequencer and
// result register around the cell chain. Depends on ple_pkg, ple_if, ple_chain.
//
//  channel | dir | beat payload                                   | handshake
//  i_cmd   | in  | command, value, position                       | valid/ready
//  o_res   | out | element, element_valid, last, count, status    | valid/ready
//
// Insert and delete commands shift the whole chain in the cycle they are taken,
// and the result lands in the output register at the same time.
// Dump of a non-empty list first enters the dump state; each element beat, sent
// when the output slot is free, emits the head cell and rotates the occupied
// cells by one, so after count rotations the list is back in order. An empty
// list dumps as a single status beat. No command is taken during a dump.
// Reset (synchronous, active low) empties the list; cell contents stay as is.
// A stalled result holds the output register; a new command is taken in the
// same cycle the pending result beat is taken.
module positional_list_engine import ple_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ple_cmd_if.sink      i_cmd,
    ple_res_if.source    o_res
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state      r_state,     n_state;
    t_cnt        r_held,      n_held;
    t_idx        r_dump_idx,  n_dump_idx;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_element,   n_element;
    logic        r_elem_vld,  n_elem_vld;
    logic        r_last,      n_last;
    t_cnt        r_count,     n_count;
    t_status     r_status,    n_status;

    t_cell_ctrl  w_ctrl;
    t_data       w_head;
    logic        w_slot_free;
    logic        w_acc;
    t_cmd        w_cmd;
    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_held_x;
    logic [7:0]  w_pos_m1;
    t_idx        w_last_idx;
    logic        w_dump_end;

    ple_chain u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .o_head (w_head)
    );

    assign w_slot_free = !r_out_valid || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_slot_free;
    assign w_acc       = i_cmd.valid && i_cmd.ready;
    assign w_cmd       = t_cmd'(i_cmd.command);
    assign w_pos       = CMP_W'(i_cmd.position);
    assign w_held_x    = CMP_W'(r_held);
    assign w_pos_m1    = i_cmd.position - 8'd1;
    assign w_last_idx  = IDX_W'(r_held - t_cnt'(1));
    assign w_dump_end  = (r_dump_idx == w_last_idx);

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_dump_idx  = r_dump_idx;
        n_out_valid = r_out_valid;
        n_element   = r_element;
        n_elem_vld  = r_elem_vld;
        n_last      = r_last;
        n_count     = r_count;
        n_status    = r_status;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.k    = '0;
        w_ctrl.data = to_store(i_cmd.value);

        // drop the pending beat once it is taken
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_acc) begin
            // default: single status beat with no element
            n_out_valid = 1'b1;
            n_element   = '0;
            n_elem_vld  = 1'b0;
            n_last      = 1'b1;
            n_status    = ST_OK;
            case (w_cmd)
                CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
                    if (w_cmd == CMD_INS_AT &&
                        (w_pos == '0 || w_pos > w_held_x + CMP_W'(1))) begin
                        n_status = ST_BADPOS;
                    end else if (r_held == t_cnt'(CAPACITY)) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.op = CELL_INS;
                        if (w_cmd == CMD_INS_FIRST) begin
                            w_ctrl.k = '0;
                        end else if (w_cmd == CMD_INS_LAST) begin
                            w_ctrl.k = IDX_W'(r_held);
                        end else begin
                            w_ctrl.k = w_pos_m1[IDX_W-1:0];
                        end
                        n_held = r_held + t_cnt'(1);
                    end
                end
                CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
                    if (r_held == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_cmd == CMD_DEL_AT &&
                                 (w_pos == '0 || w_pos > w_held_x)) begin
                        n_status = ST_BADPOS;
                    end else begin
                        w_ctrl.op = CELL_DEL;
                        if (w_cmd == CMD_DEL_FIRST) begin
                            w_ctrl.k = '0;
                        end else if (w_cmd == CMD_DEL_LAST) begin
                            w_ctrl.k = w_last_idx;
                        end else begin
                            w_ctrl.k = w_pos_m1[IDX_W-1:0];
                        end
                        n_held = r_held - t_cnt'(1);
                    end
                end
                CMD_DUMP: begin
                    if (r_held != '0) begin
                        // hold off the output; the dump sequencer fills it
                        n_out_valid = 1'b0;
                        n_state     = S_DUMP;
                        n_dump_idx  = '0;
                    end
                end
                default: n_status = ST_OK;
            endcase
            n_count = n_held;
        end

        if (r_state == S_DUMP && w_slot_free) begin
            // emit the head and rotate it to the tail of the occupied cells
            n_out_valid = 1'b1;
            n_element   = to_element(w_head);
            n_elem_vld  = 1'b1;
            n_last      = w_dump_end;
            n_count     = r_held;
            n_status    = ST_OK;
            w_ctrl.op   = CELL_ROT;
            w_ctrl.k    = w_last_idx;
            n_dump_idx  = r_dump_idx + t_idx'(1);
            if (w_dump_end) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_dump_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_dump_idx  <= n_dump_idx;
            r_out_valid <= n_out_valid;
        end
        r_element  <= n_element;
        r_elem_vld <= n_elem_vld;
        r_last     <= n_last;
        r_count    <= n_count;
        r_status   <= n_status;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.element       = r_element;
    assign o_res.element_valid = r_elem_vld;
    assign o_res.last          = r_last;
    assign o_res.count         = r_count;
    assign o_res.status        = r_status;

    // The list never grows past its capacity
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= t_cnt'(CAPACITY))
        else $error("list count exceeds capacity");

    // A beat without an element closes its command and carries zero
    a_no_elem_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_elem_vld) |-> (r_last && r_element == '0))
        else $error("element-less beat not final or nonzero");

    // The count moves only when a command is taken
    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_held))
        else $error("count changed without a command");

    // A dump beat always reports a non-empty list
    a_dump_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_elem_vld) |-> (r_count != '0 && r_status == ST_OK))
        else $error("dump beat with empty count or bad status");

endmodule
